// ----- src/kacbr_pkg.sv -----
`default_nettype none

package kacbr_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned KEY_LEN_W  = 4;
  localparam int unsigned BSIZE_W    = 17;
  localparam int unsigned ORDER_W    = 2;
  localparam int unsigned ROT_W      = 16;

  // Width of the modulo unit: dividend up to position plus rotation, divisor up to block size
  localparam int unsigned CALC_W     = 17;
  localparam int unsigned CALC_CNT_W = $clog2(CALC_W + 1);

  localparam logic [BSIZE_W-1:0] MIN_BLOCK = BSIZE_W'(57);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ONE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ONE_LEN = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_TWO     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_TWO_LEN = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_ORDER = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION    = 4'd7;

  // Stage orders
  localparam logic [ORDER_W-1:0] ORDER_AAR = 2'd0;  // add, add, rotate
  localparam logic [ORDER_W-1:0] ORDER_ARA = 2'd1;  // add, rotate, add
  localparam logic [ORDER_W-1:0] ORDER_RAA = 2'd2;  // rotate, add, add

  localparam logic MODE_DATA  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;
  localparam logic DIR_DECODE = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] data_byte;
    logic              stream_end;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              block_end;
    logic              stream_done;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_ROT   = 4'b0100,
    ST_POS   = 4'b1000
  } calc_state_e;

endpackage

`default_nettype wire

// ----- src/keyed_add_and_block_rotate_cipher_top.sv -----
`default_nettype none

// Keyed-add and block-rotate byte cipher. Takes one byte or flush tick per
// clock while in_ready_o is high and gives at most one result per clock.
// Bytes are written into one of two block banks at their rotated place,
// with any add stages before the rotation already applied; the other bank,
// once full, is read out in order with the later add stages applied, so
// output trails input by one block and flush ticks drain the last block.
// Each transfer does at most one bank read and one bank write in the same
// cycle, so the sustained rate is one item per cycle while the output is not
// stalled and no recompute runs; a result is registered in the read stage,
// alongside the bank read, and then in the output register. Both banks live
// in one memory of 2*MAX_BLOCK bytes with a registered read; it is not
// cleared after reset. After any configuration write the block recomputes
// the rotation offset and the current write address with a bit-serial
// modulo unit in two passes, and holds in_ready_o low meanwhile.
// Configuration transfers are always accepted but must only be made while the block is idle.

module keyed_add_and_block_rotate_cipher_top #(
  parameter int unsigned MAX_BLOCK = 65536,
  parameter int unsigned KEY_BYTES = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire kacbr_pkg::in_item_t                 in_item_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output kacbr_pkg::out_item_t                     out_item_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [kacbr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [kacbr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import kacbr_pkg::*;

  localparam int unsigned PW    = $clog2(MAX_BLOCK);
  localparam int unsigned DEPTH = 2 * MAX_BLOCK;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned KIW   = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [BYTE_W-1:0]    key1_q [KEY_BYTES];
  logic [BYTE_W-1:0]    key2_q [KEY_BYTES];
  logic [KEY_LEN_W-1:0] k1_len_q, k2_len_q;
  logic [BSIZE_W-1:0]   bsize_q;
  logic [ORDER_W-1:0]   order_q;
  logic                 dir_q;
  logic [ROT_W-1:0]     rot_q;
  logic                 cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_BYTES; i++) begin
        key1_q[i] <= '0;
        key2_q[i] <= '0;
      end
      k1_len_q <= KEY_LEN_W'(1);
      k2_len_q <= KEY_LEN_W'(1);
      bsize_q  <= BSIZE_W'(64);
      order_q  <= ORDER_ARA;
      dir_q    <= 1'b0;
      rot_q    <= '0;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        CFG_KEY_ONE: begin
          for (int i = 0; i < KEY_BYTES; i++) begin
            key1_q[i] <= cfg_data_i[8*i +: 8];
          end
        end
        CFG_KEY_ONE_LEN: k1_len_q <= cfg_data_i[KEY_LEN_W-1:0];
        CFG_KEY_TWO: begin
          for (int i = 0; i < KEY_BYTES; i++) begin
            key2_q[i] <= cfg_data_i[8*i +: 8];
          end
        end
        CFG_KEY_TWO_LEN: k2_len_q <= cfg_data_i[KEY_LEN_W-1:0];
        CFG_BLOCK_SIZE:  bsize_q  <= cfg_data_i[BSIZE_W-1:0];
        CFG_STAGE_ORDER: order_q  <= cfg_data_i[ORDER_W-1:0];
        CFG_DIRECTION:   dir_q    <= cfg_data_i[0];
        CFG_ROTATION:    rot_q    <= cfg_data_i[ROT_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Clamped key lengths and block size, stage selection
  logic [KEY_LEN_W-1:0] k1_len, k2_len;
  logic [CALC_W-1:0]    bs_eff;
  logic [ORDER_W-1:0]   ord, eff;
  logic                 front1, front2, back1, back2;

  always_comb begin
    k1_len = (k1_len_q == '0) ? KEY_LEN_W'(1) :
             (k1_len_q > KEY_LEN_W'(KEY_BYTES)) ? KEY_LEN_W'(KEY_BYTES) : k1_len_q;
    k2_len = (k2_len_q == '0) ? KEY_LEN_W'(1) :
             (k2_len_q > KEY_LEN_W'(KEY_BYTES)) ? KEY_LEN_W'(KEY_BYTES) : k2_len_q;
    if (bsize_q < MIN_BLOCK) begin
      bs_eff = CALC_W'(MIN_BLOCK);
    end else if (bsize_q > BSIZE_W'(MAX_BLOCK)) begin
      bs_eff = CALC_W'(MAX_BLOCK);
    end else begin
      bs_eff = CALC_W'(bsize_q);
    end
    // Decode reverses the stage sequence
    ord    = (order_q == ORDER_AAR) ? ORDER_AAR :
             (order_q == ORDER_RAA) ? ORDER_RAA : ORDER_ARA;
    eff    = (dir_q == DIR_DECODE) ? (ORDER_RAA - ord) : ord;
    front1 = (eff != ORDER_RAA);
    front2 = (eff == ORDER_AAR);
    back1  = (eff != ORDER_AAR);
    back2  = (eff == ORDER_RAA);
  end

  function automatic logic [KIW-1:0] key_next(input logic [KIW-1:0]       idx,
                                              input logic [KEY_LEN_W-1:0] len);
    logic [KEY_LEN_W-1:0] inc;
    inc = KEY_LEN_W'(idx) + KEY_LEN_W'(1);
    return (inc >= len) ? '0 : KIW'(inc);
  endfunction

  // ---------------------------------------------------------------------
  // Rotation offset and write address recompute after configuration
  // ---------------------------------------------------------------------
  calc_state_e       st_q, st_d;
  logic              mod_start, mod_done;
  logic [CALC_W-1:0] mod_dvd, mod_rem, rot_adj;

  kacbr_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dvd),
    .divisor_i  (bs_eff),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Decode rotates the other way: (size - r) mod size
  assign rot_adj = ((dir_q != DIR_DECODE) || (mod_rem == '0)) ? mod_rem : bs_eff - mod_rem;

  // ---------------------------------------------------------------------
  // Bank control state
  // ---------------------------------------------------------------------
  logic [PW-1:0]  wp_q, wp_d, rp_q, rp_d, wa_q, wa_d, rot_eff_q, rot_eff_d;
  logic           wb_q, wb_d, pend_q, pend_d, final_q, final_d;
  logic [KIW-1:0] f1_q, f1_d, f2_q, f2_d, b1_q, b1_d, b2_q, b2_d;

  logic              accept, rd_en, wr_en, rd_last, wr_last;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [BYTE_W-1:0] front_amt, back_amt, wr_data, rd_data;
  logic [CALC_W-1:0] wa_inc;

  // Read-side pipeline stage and output register
  logic              s1_valid_q, s1_valid_d, s1_last_q, s1_final_q, s1_move;
  logic [BYTE_W-1:0] s1_amt_q;
  logic              out_valid_q;
  out_item_t         out_q;

  // Accept while idle and the read stage is free or can hand its result on
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = (st_q == ST_IDLE) && (!s1_valid_q || s1_move);
  assign accept     = in_valid_i && in_ready_o;
  assign rd_en      = accept && pend_q;
  assign wr_en      = accept && (in_item_i.mode == MODE_DATA);

  assign rd_last = (CALC_W'(rp_q) + CALC_W'(1)) >= bs_eff;
  assign wr_last = (CALC_W'(wp_q) + CALC_W'(1)) >= bs_eff;
  assign wa_inc  = CALC_W'(wa_q) + CALC_W'(1);

  // Pending bank is the one not being written
  assign rd_addr = wb_q ? AW'(rp_q) : AW'(MAX_BLOCK) + AW'(rp_q);
  assign wr_addr = wb_q ? AW'(MAX_BLOCK) + AW'(wa_q) : AW'(wa_q);

  always_comb begin
    front_amt = (front1 ? key1_q[f1_q] : '0) + (front2 ? key2_q[f2_q] : '0);
    back_amt  = (back1 ? key1_q[b1_q] : '0) + (back2 ? key2_q[b2_q] : '0);
    wr_data   = (dir_q == DIR_DECODE) ? in_item_i.data_byte - front_amt
                                      : in_item_i.data_byte + front_amt;
  end

  always_comb begin
    st_d      = st_q;
    mod_start = 1'b0;
    mod_dvd   = '0;
    rot_eff_d = rot_eff_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    wa_d      = wa_q;
    wb_d      = wb_q;
    pend_d    = pend_q;
    final_d   = final_q;
    f1_d      = f1_q;
    f2_d      = f2_q;
    b1_d      = b1_q;
    b2_d      = b2_q;

    case (st_q)
      ST_IDLE: ;
      ST_START: begin
        mod_start = 1'b1;
        mod_dvd   = CALC_W'(rot_q);
        st_d      = ST_ROT;
      end
      ST_ROT: begin
        if (mod_done) begin
          rot_eff_d = PW'(rot_adj);
          mod_start = 1'b1;
          mod_dvd   = CALC_W'(wp_q) + rot_adj;
          st_d      = ST_POS;
        end
      end
      ST_POS: begin
        if (mod_done) begin
          wa_d = PW'(mod_rem);
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
    if (cfg_fire) begin
      st_d = ST_START;
    end

    // Drain one byte of the pending block first
    if (rd_en) begin
      b1_d = key_next(b1_q, k1_len);
      b2_d = key_next(b2_q, k2_len);
      if (rd_last) begin
        pend_d = 1'b0;
        rp_d   = '0;
        if (final_q) begin
          b1_d    = '0;
          b2_d    = '0;
          final_d = 1'b0;
        end
      end else begin
        rp_d = rp_q + PW'(1);
      end
    end

    // Then write the data byte; a full block becomes the pending one
    if (wr_en) begin
      f1_d = key_next(f1_q, k1_len);
      f2_d = key_next(f2_q, k2_len);
      if (wr_last) begin
        wb_d    = ~wb_q;
        pend_d  = 1'b1;
        rp_d    = '0;
        final_d = in_item_i.stream_end;
        wp_d    = '0;
        wa_d    = rot_eff_q;
        if (in_item_i.stream_end) begin
          f1_d = '0;
          f2_d = '0;
        end
      end else begin
        wp_d = wp_q + PW'(1);
        wa_d = (wa_inc == bs_eff) ? '0 : PW'(wa_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      rot_eff_q <= '0;
      wp_q      <= '0;
      rp_q      <= '0;
      wa_q      <= '0;
      wb_q      <= 1'b0;
      pend_q    <= 1'b0;
      final_q   <= 1'b0;
      f1_q      <= '0;
      f2_q      <= '0;
      b1_q      <= '0;
      b2_q      <= '0;
    end else begin
      st_q      <= st_d;
      rot_eff_q <= rot_eff_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      wa_q      <= wa_d;
      wb_q      <= wb_d;
      pend_q    <= pend_d;
      final_q   <= final_d;
      f1_q      <= f1_d;
      f2_q      <= f2_d;
      b1_q      <= b1_d;
      b2_q      <= b2_d;
    end
  end

  kacbr_bank_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // ---------------------------------------------------------------------
  // Read stage: hold the key amount and flags while the bank read is out
  // ---------------------------------------------------------------------
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (rd_en) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_amt_q   <= back_amt;
      s1_last_q  <= rd_last;
      s1_final_q <= rd_last && final_q;
    end
    if (s1_move) begin
      out_q.out_byte    <= (dir_q == DIR_DECODE) ? rd_data - s1_amt_q : rd_data + s1_amt_q;
      out_q.block_end   <= s1_last_q;
      out_q.stream_done <= s1_final_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> !in_ready_o)
    else $error("item transfer possible right after a configuration write");

  a_addr_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> ((CALC_W'(wa_q) < bs_eff) && (CALC_W'(rot_eff_q) < bs_eff)))
    else $error("rotated write address or offset outside the block");

  a_block_goes_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && wr_last) |=> (pend_q && (wb_q != $past(wb_q))))
    else $error("completed block did not become pending");

  a_stage_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |=> (s1_valid_q && !$past(rd_en)))
    else $error("read stage dropped or overwritten while stalled");

endmodule

`default_nettype wire

// ----- src/kacbr_bank_ram.sv -----
`default_nettype none

module kacbr_bank_ram #(
  parameter int unsigned DEPTH = 131072,
  parameter int unsigned AW    = 17
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [7:0]    wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [7:0]    rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- src/kacbr_mod_unit.sv -----
`default_nettype none

module kacbr_mod_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [kacbr_pkg::CALC_W-1:0] dividend_i,
  input  wire logic [kacbr_pkg::CALC_W-1:0] divisor_i,
  output logic                             done_o,
  output logic      [kacbr_pkg::CALC_W-1:0] rem_o
);

  import kacbr_pkg::*;

  logic [CALC_W-1:0]     dvd_q, rem_q, rem_d;
  logic [CALC_CNT_W-1:0] cnt_q;
  logic                  run_q, done_q;
  logic [CALC_W:0]       trial;

  // One quotient bit per cycle, restoring form; divisor is held by the caller
  always_comb begin
    trial = {rem_q, dvd_q[CALC_W-1]};
    if (trial >= {1'b0, divisor_i}) begin
      trial = trial - {1'b0, divisor_i};
    end
    rem_d = trial[CALC_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CALC_CNT_W'(CALC_W);
    end else if (run_q) begin
      cnt_q <= cnt_q - CALC_CNT_W'(1);
      if (cnt_q == CALC_CNT_W'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[CALC_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- sim/keyed_add_and_block_rotate_cipher_top_tb.sv -----
`timescale 1ns / 100ps

module keyed_add_and_block_rotate_cipher_top_tb;
  import kacbr_pkg::*;

  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned MAX_BLK       = 65536;
  localparam int unsigned KEY_MAX       = 8;
  localparam int unsigned RANDOM_ITEMS  = 500;
  // Margin for the tail once no result is owed any more
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  // Stage order value outside the three named ones; behaves as add, rotate, add
  localparam logic [ORDER_W-1:0]   ORDER_SPARE = 2'd3;
  // Register index that selects nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 4'd15;

  // Cipher tracker: own copy of registers, banks and counters, plus the
  // queue of output bytes still owed by the block.
  class cipher_scoreboard;
    logic [63:0]          key_a, key_b;
    logic [KEY_LEN_W-1:0] len_a, len_b;
    logic [BSIZE_W-1:0]   blk_size;
    logic [ORDER_W-1:0]   order;
    logic                 dir;
    logic [ROT_W-1:0]     rot;
    bit [7:0]             bank [2*MAX_BLK];
    int unsigned          wr_pos, rd_pos;
    bit                   wr_bank, pend_full, pend_final;
    logic [5:0]           front_kp, back_kp;
    out_item_t            expected_bytes [$];
    int unsigned          fail_count;

    function new();
      key_a = '0; len_a = 4'd1; key_b = '0; len_b = 4'd1;
      blk_size = 17'd64; order = ORDER_ARA; dir = 1'b0; rot = '0;
      wr_pos = 0; rd_pos = 0; wr_bank = 0; pend_full = 0; pend_final = 0;
      front_kp = '0; back_kp = '0; fail_count = 0;
    endfunction

    function int unsigned key_len(logic [KEY_LEN_W-1:0] len);
      if (len == 0) return 1;
      if (len > KEY_MAX) return KEY_MAX;
      return len;
    endfunction

    function int unsigned block_len();
      if (blk_size < MIN_BLOCK) return MIN_BLOCK;
      if (blk_size > MAX_BLK) return MAX_BLK;
      return blk_size;
    endfunction

    // Add or subtract the selected key bytes at the given key positions
    function logic [7:0] keyed(logic [7:0] b, bit use_a, bit use_b, logic [5:0] kp);
      logic [7:0] amt;
      amt = 8'd0;
      if (use_a) amt = amt + key_a[8*kp[2:0] +: 8];
      if (use_b) amt = amt + key_b[8*kp[5:3] +: 8];
      return (dir == DIR_DECODE) ? b - amt : b + amt;
    endfunction

    // Step both key indexes; an index past a shortened key wraps to zero
    function logic [5:0] next_kp(logic [5:0] kp);
      int unsigned ia, ib;
      ia = kp[2:0];
      ib = kp[5:3];
      ia = (ia + 1 >= key_len(len_a)) ? 0 : ia + 1;
      ib = (ib + 1 >= key_len(len_b)) ? 0 : ib + 1;
      return {ib[2:0], ia[2:0]};
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_KEY_ONE:     key_a = data;
        CFG_KEY_ONE_LEN: len_a = data[KEY_LEN_W-1:0];
        CFG_KEY_TWO:     key_b = data;
        CFG_KEY_TWO_LEN: len_b = data[KEY_LEN_W-1:0];
        CFG_BLOCK_SIZE:  blk_size = data[BSIZE_W-1:0];
        CFG_STAGE_ORDER: order = data[ORDER_W-1:0];
        CFG_DIRECTION:   dir = data[0];
        CFG_ROTATION:    rot = data[ROT_W-1:0];
        default: ;
      endcase
    endfunction

    // Note one accepted input transfer: drain a pending byte, then store
    function void predict_transfer(in_item_t it);
      int unsigned bs, ord, eff, rp, wp, shift, addr;
      bit fa, fb, ba, bb, last;
      logic [7:0] b;
      out_item_t res;
      bs = block_len();
      ord = (order == ORDER_AAR) ? 0 : (order == ORDER_RAA) ? 2 : 1;
      eff = (dir == DIR_DECODE) ? 2 - ord : ord;
      fa = (eff != 2);
      fb = (eff == 0);
      ba = (eff != 0);
      bb = (eff == 2);
      if (pend_full) begin
        rp = rd_pos % MAX_BLK;
        b = bank[(wr_bank ? 0 : MAX_BLK) + rp];
        last = (rp + 1 >= bs);
        res.out_byte = keyed(b, ba, bb, back_kp);
        res.block_end = last;
        res.stream_done = last && pend_final;
        back_kp = next_kp(back_kp);
        expected_bytes = {expected_bytes, res};
        if (last) begin
          pend_full = 0;
          rd_pos = 0;
          if (pend_final) begin
            back_kp = '0;
            pend_final = 0;
          end
        end else begin
          rd_pos = rp + 1;
        end
      end
      if (it.mode == MODE_DATA) begin
        shift = rot % bs;
        wp = wr_pos % MAX_BLK;
        if (dir == DIR_DECODE) shift = (bs - shift) % bs;
        addr = (wp + shift) % bs;
        bank[(wr_bank ? MAX_BLK : 0) + addr] = keyed(it.data_byte, fa, fb, front_kp);
        front_kp = next_kp(front_kp);
        if (wp + 1 >= bs) begin
          wr_bank = !wr_bank;
          pend_full = 1;
          rd_pos = 0;
          pend_final = it.stream_end;
          wr_pos = 0;
          if (it.stream_end) front_kp = '0;
        end else begin
          wr_pos = wp + 1;
        end
      end
    endfunction

    function void report_field(string field, logic [7:0] want, logic [7:0] got);
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t ns: result with nothing expected, expected none, actual %0h/%0b/%0b",
                 $time, got.out_byte, got.block_end, got.stream_done);
        fail_count++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) report_field("out_byte", want.out_byte, got.out_byte);
      if (got.block_end !== want.block_end)
        report_field("block_end", want.block_end, got.block_end);
      if (got.stream_done !== want.stream_done)
        report_field("stream_done", want.stream_done, got.stream_done);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_item_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  cipher_scoreboard sb = new();

  // Idle styles: 0 never idle, 1 wait 0..18 every item, 2 wait now and then
  int unsigned in_style  = 1;
  int unsigned out_style = 1;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  keyed_add_and_block_rotate_cipher_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  // Sample every transfer at the rising edge. Check the output first: it can
  // never stem from an input taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.predict_transfer(in_item_i);
    end
  end

  function automatic int unsigned draw_gap(int unsigned style);
    case (style)
      0: return 0;
      1: return $urandom_range(0, 18);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  // Present one item; hold valid and payload until the transfer happens
  task automatic send_item(logic mode, logic [7:0] data, logic last);
    int unsigned gap;
    in_item_t it;
    gap = draw_gap(in_style);
    it.mode = mode;
    it.data_byte = data;
    it.stream_end = last;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic end_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic end_config();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Whole blocks of random bytes. Noisy streams carry stray flush ticks and
  // stream_end marks on bytes that do not complete a block.
  task automatic send_stream(int unsigned blocks, bit mark_end, bit noisy);
    int unsigned total;
    total = blocks * sb.block_len();
    for (int unsigned i = 0; i < total; i++) begin
      if (noisy && $urandom_range(0, 15) == 0)
        send_item(MODE_FLUSH, 8'($urandom), 1'($urandom));
      send_item(MODE_DATA, 8'($urandom),
                (i == total - 1) ? mark_end : (noisy && $urandom_range(0, 9) == 0));
    end
  endtask

  // Flush out whatever block is pending, plus a few ticks with nothing left
  task automatic drain();
    int unsigned ticks;
    ticks = sb.block_len() + $urandom_range(0, 3);
    repeat (ticks) send_item(MODE_FLUSH, 8'($urandom), 1'($urandom));
  endtask

  // Drop valid and wait until every owed byte has come back
  task automatic settle();
    end_input();
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_key();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [KEY_LEN_W-1:0] pick_len();
    return ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, KEY_MAX));
  endfunction

  // Rewrite a random subset of registers, junk in the unused upper bits
  task automatic randomise_config();
    logic [63:0] junk;
    int unsigned bs, span;
    junk = {$urandom, $urandom};
    span = sb.block_len();
    if ($urandom_range(0, 1)) write_reg(CFG_KEY_ONE, pick_key());
    if ($urandom_range(0, 1)) write_reg(CFG_KEY_ONE_LEN, {junk[63:KEY_LEN_W], pick_len()});
    if ($urandom_range(0, 1)) write_reg(CFG_KEY_TWO, pick_key());
    if ($urandom_range(0, 1)) write_reg(CFG_KEY_TWO_LEN, {junk[63:KEY_LEN_W], pick_len()});
    if ($urandom_range(0, 1)) begin
      bs = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 56) : $urandom_range(57, 96);
      span = (bs < MIN_BLOCK) ? MIN_BLOCK : bs;
      write_reg(CFG_BLOCK_SIZE, {junk[63:BSIZE_W], bs[BSIZE_W-1:0]});
    end
    if ($urandom_range(0, 1))
      write_reg(CFG_STAGE_ORDER, {junk[63:ORDER_W], 2'($urandom)});
    if ($urandom_range(0, 1)) write_reg(CFG_DIRECTION, {junk[63:1], 1'($urandom)});
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0: write_reg(CFG_ROTATION, {junk[63:ROT_W], 16'($urandom)});
        1: write_reg(CFG_ROTATION, {junk[63:ROT_W], 16'(span - 1)});
        2: write_reg(CFG_ROTATION, '0);
        default: write_reg(CFG_ROTATION, {junk[63:ROT_W], 16'($urandom_range(0, 2 * span))});
      endcase
    end
    if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, junk);
    end_config();
  endtask

  // Output side: stall for a drawn number of cycles, then take one transfer
  initial begin : result_sink
    int unsigned gap, taken;
    taken = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      gap = draw_gap(out_style);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && rst_ni));
      taken++;
      if (taken % 32 == 0) out_style = $urandom_range(0, 2);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] opening [7];
    int unsigned start;
    opening = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hAA, 8'h55};
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: flush ticks with nothing pending give nothing back,
    // then one block of edge bytes with a stray stream_end on the second byte.
    send_item(MODE_FLUSH, 8'hFF, 1'b1);
    send_item(MODE_FLUSH, 8'h00, 1'b0);
    for (int unsigned i = 0; i < sb.block_len(); i++)
      send_item(MODE_DATA, (i < 7) ? opening[i] : 8'($urandom),
                (i == 1) || (i == sb.block_len() - 1));
    drain();
    settle();

    // Full keys, smallest block, rotation one short of the block
    write_reg(CFG_KEY_ONE, '1);
    write_reg(CFG_KEY_ONE_LEN, 64'(KEY_MAX));
    write_reg(CFG_KEY_TWO, 64'h0123_4567_89AB_CDEF);
    write_reg(CFG_KEY_TWO_LEN, 64'(KEY_MAX));
    write_reg(CFG_BLOCK_SIZE, 64'(MIN_BLOCK));
    write_reg(CFG_STAGE_ORDER, 64'(ORDER_AAR));
    write_reg(CFG_DIRECTION, '0);
    write_reg(CFG_ROTATION, 64'(MIN_BLOCK - 1));
    end_config();
    send_stream(2, 1'b1, 1'b0);
    drain();
    settle();

    // Decode, block size zero, rotation far past the block, key lengths off range
    write_reg(CFG_DIRECTION, 64'(DIR_DECODE));
    write_reg(CFG_STAGE_ORDER, 64'(ORDER_RAA));
    write_reg(CFG_BLOCK_SIZE, '0);
    write_reg(CFG_ROTATION, 64'hFFFF);
    write_reg(CFG_KEY_ONE_LEN, '0);
    write_reg(CFG_KEY_TWO_LEN, 64'hF);
    end_config();
    send_stream(2, 1'b1, 1'b0);
    drain();
    settle();

    // Spare order code; a stream left open so the key indexes stay put,
    // then shorten both keys beneath them before the next stream
    write_reg(CFG_STAGE_ORDER, 64'(ORDER_SPARE));
    write_reg(CFG_DIRECTION, '0);
    write_reg(CFG_BLOCK_SIZE, 64'(MIN_BLOCK - 1));
    write_reg(CFG_KEY_ONE_LEN, 64'd5);
    write_reg(CFG_KEY_TWO_LEN, 64'(KEY_MAX));
    end_config();
    send_stream(1, 1'b0, 1'b0);
    drain();
    settle();
    write_reg(CFG_KEY_ONE_LEN, 64'd2);
    write_reg(CFG_KEY_TWO_LEN, 64'd1);
    end_config();
    send_stream(1, 1'b1, 1'b0);
    drain();
    settle();

    // Random streams: mostly well-formed, some noisy or left open; now and
    // then run straight into the next stream so the old block drains there.
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        drain();
        settle();
        randomise_config();
      end
      in_style = $urandom_range(0, 2);
      send_stream($urandom_range(1, 3), $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0);
    end
    drain();
    settle();

    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/kacbr_pkg.sv
src/kacbr_bank_ram.sv
src/kacbr_mod_unit.sv
src/keyed_add_and_block_rotate_cipher_top.sv
sim/keyed_add_and_block_rotate_cipher_top_tb.sv
